// File: design/bpc_pkg.sv
// Shared types and constants for the button press classifier.
// No dependencies; imported by every module of the block.
package bpc_pkg;

   localparam int unsigned ThrWidth   = 16;
   localparam int unsigned StampWidth = 32;
   localparam int unsigned TallyWidth = 8;
   localparam int unsigned CodeWidth  = 2;
   localparam int unsigned AddrWidth  = 4;
   localparam int unsigned DataWidth  = 32;

   // event codes
   localparam logic [CodeWidth-1:0] EV_NONE   = 2'd0;
   localparam logic [CodeWidth-1:0] EV_SINGLE = 2'd1;
   localparam logic [CodeWidth-1:0] EV_DOUBLE = 2'd2;
   localparam logic [CodeWidth-1:0] EV_LONG   = 2'd3;

   // register indexes (paddr[3:2])
   localparam logic [1:0] REG_DOUBLE_WINDOW = 2'd0;
   localparam logic [1:0] REG_LONG_PRESS    = 2'd1;
   localparam logic [1:0] REG_SINGLE_CONF   = 2'd2;

   localparam logic [ThrWidth-1:0] DOUBLE_WINDOW_RST = 16'd1000;
   localparam logic [ThrWidth-1:0] LONG_PRESS_RST    = 16'd3000;
   localparam logic [ThrWidth-1:0] SINGLE_CONF_RST   = 16'd300;

   typedef struct packed {
      logic [ThrWidth-1:0] double_window_ms;
      logic [ThrWidth-1:0] long_press_ms;
      logic [ThrWidth-1:0] single_confirm_ms;
   } thresholds_type;

endpackage

// File: design/bpc_csr.sv
// Configuration registers of the button press classifier, APB-style access.
// Depends on bpc_pkg.
module bpc_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [bpc_pkg::AddrWidth-1:0] csr_paddr,
   input  logic [bpc_pkg::DataWidth-1:0] csr_pwdata,
   output logic [bpc_pkg::DataWidth-1:0] csr_prdata,
   output logic                          csr_pready,
   output bpc_pkg::thresholds_type       thr
);
   import bpc_pkg::*;

   thresholds_type thr_ff, thr_in;
   logic           wr_en;
   logic [1:0]     reg_idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign reg_idx    = csr_paddr[3:2];

   always_comb begin
      thr_in = thr_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_DOUBLE_WINDOW: thr_in.double_window_ms  = csr_pwdata[ThrWidth-1:0];
            REG_LONG_PRESS:    thr_in.long_press_ms     = csr_pwdata[ThrWidth-1:0];
            REG_SINGLE_CONF:   thr_in.single_confirm_ms = csr_pwdata[ThrWidth-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_DOUBLE_WINDOW: csr_prdata = DataWidth'(thr_ff.double_window_ms);
         REG_LONG_PRESS:    csr_prdata = DataWidth'(thr_ff.long_press_ms);
         REG_SINGLE_CONF:   csr_prdata = DataWidth'(thr_ff.single_confirm_ms);
         default:           csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff.double_window_ms  <= DOUBLE_WINDOW_RST;
         thr_ff.long_press_ms     <= LONG_PRESS_RST;
         thr_ff.single_confirm_ms <= SINGLE_CONF_RST;
      end else begin
         thr_ff <= thr_in;
      end
   end

   assign thr = thr_ff;

endmodule

// File: design/bpc_step.sv
// Press/release/single/double/long classification step and the button state it keeps.
// Depends on bpc_pkg; state advances only when advance is high.
module bpc_step (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           advance,
   input  logic                           level,
   input  logic [bpc_pkg::StampWidth-1:0] now_ms,
   input  bpc_pkg::thresholds_type        thr,
   output logic [bpc_pkg::CodeWidth-1:0]  code
);
   import bpc_pkg::*;

   logic                  pressed_ff, pressed_in;
   logic [StampWidth-1:0] press_stamp_ff, press_stamp_in;
   logic [StampWidth-1:0] last_stamp_ff, last_stamp_in;
   logic [TallyWidth-1:0] tally_ff, tally_in;
   logic                  long_ff, long_in;
   logic                  pending_ff, pending_in;

   logic                  press_edge, release_edge;
   logic [StampWidth-1:0] gap_prev, hold_time, since_last;

   assign press_edge   = !level && !pressed_ff;
   assign release_edge = level && pressed_ff;
   assign gap_prev     = now_ms - last_stamp_ff;

   // a press in this step sets both stamps to now, so the later
   // differences are taken against the updated values
   assign hold_time  = now_ms - press_stamp_in;
   assign since_last = now_ms - last_stamp_in;

   always_comb begin
      pressed_in     = pressed_ff;
      press_stamp_in = press_stamp_ff;
      last_stamp_in  = last_stamp_ff;
      tally_in       = tally_ff;
      long_in        = long_ff;
      pending_in     = pending_ff;
      code           = EV_NONE;

      if (press_edge) begin
         pressed_in     = 1'b1;
         press_stamp_in = now_ms;
         last_stamp_in  = now_ms;
         if (gap_prev < StampWidth'(thr.double_window_ms)) begin
            tally_in = tally_ff + TallyWidth'(1);
         end else begin
            tally_in = TallyWidth'(1);
         end
      end

      if (release_edge) begin
         pressed_in = 1'b0;
         if (!long_ff) begin
            if (tally_ff == TallyWidth'(1)) begin
               pending_in = 1'b1;
            end else if (tally_ff == TallyWidth'(2)) begin
               code       = EV_DOUBLE;
               tally_in   = '0;
               pending_in = 1'b0;
            end
         end
         long_in = 1'b0;
      end

      if (pressed_in && hold_time > StampWidth'(thr.long_press_ms) && !long_in) begin
         long_in    = 1'b1;
         code       = EV_LONG;
         pending_in = 1'b0;
      end

      if (pending_in && since_last > StampWidth'(thr.single_confirm_ms)) begin
         code       = EV_SINGLE;
         pending_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pressed_ff     <= 1'b0;
         press_stamp_ff <= '0;
         last_stamp_ff  <= '0;
         tally_ff       <= '0;
         long_ff        <= 1'b0;
         pending_ff     <= 1'b0;
      end else if (advance) begin
         pressed_ff     <= pressed_in;
         press_stamp_ff <= press_stamp_in;
         last_stamp_ff  <= last_stamp_in;
         tally_ff       <= tally_in;
         long_ff        <= long_in;
         pending_ff     <= pending_in;
      end
   end

endmodule

// File: design/button_press_classifier.sv
// Button press classifier: one event word per button sample.
// A sample passes the input register and then the result register, which raises rsp_valid;
// a stalled result register holds the next sample in the input register.
// Throughput: one word per cycle while rsp_ready is high; the step logic is three 32-bit subtract/compares.
// Reset (synchronous, active high): empties both registers, clears button state,
// and loads the thresholds with 1000, 3000 and 300 ms.
module button_press_classifier (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_button_level,
   input  logic [bpc_pkg::StampWidth-1:0] req_now_ms,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [bpc_pkg::CodeWidth-1:0] rsp_event_code,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [bpc_pkg::AddrWidth-1:0] csr_paddr,
   input  logic [bpc_pkg::DataWidth-1:0] csr_pwdata,
   output logic [bpc_pkg::DataWidth-1:0] csr_prdata,
   output logic                          csr_pready
);
   import bpc_pkg::*;

   thresholds_type        thr;
   logic                  in_valid_ff;
   logic                  level_ff;
   logic [StampWidth-1:0] now_ff;
   logic                  out_valid_ff;
   logic [CodeWidth-1:0]  code_ff, code_in;
   logic                  out_free, advance, req_take;

   assign out_free  = !out_valid_ff || rsp_ready;
   assign advance   = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || advance;
   assign req_take  = req_valid && req_ready;

   bpc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .thr         (thr)
   );

   bpc_step u_step (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .level   (level_ff),
      .now_ms  (now_ff),
      .thr     (thr),
      .code    (code_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_take) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         level_ff <= req_button_level;
         now_ff   <= req_now_ms;
      end
      if (advance) begin
         code_ff <= code_in;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_event_code = code_ff;

endmodule

// File: design/bpc_checker.sv
// Port-level checks for the button press classifier, bound to the top level.
// Depends on bpc_pkg and button_press_classifier.
module bpc_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_ready,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic [bpc_pkg::CodeWidth-1:0]  rsp_event_code,
   input logic                           csr_psel,
   input logic                           csr_penable,
   input logic                           csr_pwrite,
   input logic [bpc_pkg::AddrWidth-1:0]  csr_paddr,
   input logic [bpc_pkg::DataWidth-1:0]  csr_pwdata,
   input logic [bpc_pkg::DataWidth-1:0]  csr_prdata
);
   import bpc_pkg::*;

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_event_code))
      else $error("rsp word changed while stalled");

   // no result word right after reset
   a_rsp_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid after reset");

   // a drained output never back-pressures the input
   a_no_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_ready |-> req_ready)
      else $error("req_ready low with rsp_ready high");

   // a written threshold reads back at the same address
   a_csr_rdback: assert property (@(posedge clock) disable iff (reset)
      csr_psel && csr_penable && csr_pwrite && csr_paddr[3:2] != 2'd3 |=>
      csr_paddr[3:2] != $past(csr_paddr[3:2]) ||
      csr_prdata == DataWidth'($past(csr_pwdata[ThrWidth-1:0])))
      else $error("csr readback mismatch");

endmodule

bind button_press_classifier bpc_checker u_bpc_checker (
   .clock          (clock),
   .reset          (reset),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_event_code (rsp_event_code),
   .csr_psel       (csr_psel),
   .csr_penable    (csr_penable),
   .csr_pwrite     (csr_pwrite),
   .csr_paddr      (csr_paddr),
   .csr_pwdata     (csr_pwdata),
   .csr_prdata     (csr_prdata)
);
